>>> rtl/cic_pkg.sv
package cic_pkg;

    // Number of interrupt sources taking part in the priority pick (1 to 8).
    localparam int NUM_SOURCES = 5;

    localparam int SRC_W = 3;
    localparam int VEC_W = 7;

    // Event kinds carried on the input stream.
    typedef enum logic [2:0] {
        MODE_CHECK     = 3'd0,
        MODE_REQUEST   = 3'd1,
        MODE_ENABLE    = 3'd2,
        MODE_DISABLE   = 3'd3,
        MODE_HALT_ARM  = 3'd4,
        MODE_HALT_QRY  = 3'd5,
        MODE_WR_MASK   = 3'd6,
        MODE_WR_FLAGS  = 3'd7
    } mode_t;

    // Delayed-enable schedule loads.
    localparam logic [4:0] SCHED_DELAY_EN  = 5'h12;
    localparam logic [4:0] SCHED_DELAY_DIS = 5'h02;
    localparam logic [4:0] SCHED_RESET     = 5'h01;

    localparam logic [7:0] FLAGS_RESET = 8'hE1;
    localparam logic [7:0] MASK_RESET  = 8'h00;

    localparam logic [VEC_W-1:0] VEC_BASE     = 7'h40;
    localparam logic [SRC_W-1:0] JOYPAD_INDEX = 3'd4;

    typedef struct packed {
        mode_t       mode;
        logic        instant;
        logic [2:0]  source;
        logic [15:0] program_counter;
        logic [7:0]  write_value;
    } item_t;

    typedef struct packed {
        logic             pending;
        logic             serviced;
        logic [VEC_W-1:0] vector;
        logic [SRC_W-1:0] chosen_source;
        logic             joypad_wake;
        logic             halt_bug;
        logic [7:0]       mask_now;
        logic [7:0]       flags_now;
        logic             master_now;
    } result_t;

    typedef struct packed {
        logic        master_enable;
        logic [4:0]  enable_schedule;
        logic [7:0]  enable_mask;
        logic [7:0]  request_flags;
        logic        halt_latched;
        logic [15:0] halt_address;
    } ctl_state_t;

endpackage

>>> rtl/cic_pick.sv
module cic_pick
    import cic_pkg::*;
(
    input  logic [7:0]       active,
    output logic             found,
    output logic [SRC_W-1:0] index
);

    // Lowest enabled source wins: scan from the top so the lowest hit lands last.
    always_comb
    begin
        found = 1'b0;
        index = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--)
        begin
            if (active[i])
            begin
                found = 1'b1;
                index = SRC_W'(i);
            end
        end
    end

endmodule

>>> rtl/cic_step.sv
module cic_step
    import cic_pkg::*;
(
    input  item_t      item,
    input  ctl_state_t cur,
    output ctl_state_t nxt,
    output result_t    res
);

    logic [7:0]       active;
    logic             found;
    logic [SRC_W-1:0] index;
    logic [4:0]       sched_dec;
    logic             me_tick;
    logic [4:0]       sched_tick;

    assign active = cur.enable_mask & cur.request_flags;

    cic_pick u_pick
    (
        .active (active),
        .found  (found),
        .index  (index)
    );

    // Advance the delayed-enable schedule by one check.
    always_comb
    begin
        sched_dec  = cur.enable_schedule - 5'd1;
        me_tick    = cur.master_enable;
        sched_tick = cur.enable_schedule;
        if (cur.enable_schedule != 5'd0)
        begin
            if (sched_dec[3:0] == 4'd0)
            begin
                me_tick    = sched_dec[4];
                sched_tick = 5'd0;
            end
            else
            begin
                sched_tick = sched_dec;
            end
        end
    end

    always_comb
    begin
        nxt = cur;
        res = '0;
        case (item.mode)
            MODE_CHECK:
            begin
                nxt.enable_schedule = sched_tick;
                nxt.master_enable   = me_tick;
                if (found)
                begin
                    res.pending       = 1'b1;
                    res.chosen_source = index;
                    res.vector        = VEC_BASE + VEC_W'({index, 3'b000});
                    res.joypad_wake   = (index == JOYPAD_INDEX);
                    res.serviced      = me_tick;
                    if (me_tick)
                    begin
                        nxt.master_enable = 1'b0;
                        nxt.request_flags = cur.request_flags & ~(8'd1 << index);
                    end
                end
            end
            MODE_REQUEST:
            begin
                if ({1'b0, item.source} < 4'(NUM_SOURCES))
                begin
                    nxt.request_flags = cur.request_flags | (8'd1 << item.source);
                end
            end
            MODE_ENABLE:
            begin
                nxt.master_enable   = item.instant;
                nxt.enable_schedule = item.instant ? 5'd0 : SCHED_DELAY_EN;
            end
            MODE_DISABLE:
            begin
                if (item.instant)
                begin
                    nxt.master_enable   = 1'b0;
                    nxt.enable_schedule = 5'd0;
                end
                else
                begin
                    nxt.enable_schedule = SCHED_DELAY_DIS;
                end
            end
            MODE_HALT_ARM:
            begin
                if ((active != 8'd0) && !cur.master_enable)
                begin
                    nxt.halt_latched = 1'b1;
                    nxt.halt_address = item.program_counter;
                end
                else
                begin
                    nxt.halt_latched = 1'b0;
                end
            end
            MODE_HALT_QRY:
            begin
                if (cur.halt_latched && (item.program_counter == cur.halt_address))
                begin
                    res.halt_bug     = 1'b1;
                    nxt.halt_latched = 1'b0;
                end
            end
            MODE_WR_MASK:
            begin
                nxt.enable_mask = item.write_value;
            end
            MODE_WR_FLAGS:
            begin
                nxt.request_flags = item.write_value;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        res.mask_now   = nxt.enable_mask;
        res.flags_now  = nxt.request_flags;
        res.master_now = nxt.master_enable;
    end

endmodule

>>> rtl/cpu_interrupt_controller_core.sv
// Fixed-priority interrupt controller for an emulated CPU. Each input transfer
// is one CPU event (kind in s_tuser): instruction-boundary check, interrupt
// request, enable or disable of the master enable (instant, or delayed through
// a small schedule that counts checks), halt-bug arm and query, and writes of
// the enable mask and request flag bytes. A check picks the lowest source whose
// mask and request bits are both set and reports vector 0x40 + 8 * index; when
// the master enable, after the check's schedule step, is set the call is taken,
// clearing that request bit and the master enable. Every event yields exactly
// one output transfer carrying the pick, the halt-bug flag and the mask, flags
// and master enable after the event. The path from input transfer to output
// valid is one input register, then the event logic and controller state
// update in a single pass into the output register. One event is taken every
// cycle while the output side is not stalled; the state update feeds straight
// back for the next event, and the output register keeps accepting while a
// result is held as long as the downstream side takes it.
// After reset: master enable set, schedule armed so the first check clears the
// master enable, mask 0x00, flags 0xE1, halt latch clear.
module cpu_interrupt_controller_core
    import cic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] instant, [3:1] source, [19:4] program_counter, [27:20] write_value,
    // [31:28] zero
    input  logic [31:0] s_tdata,
    // [2:0] mode
    input  logic [2:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] pending, [1] serviced, [8:2] vector, [11:9] chosen_source,
    // [12] joypad_wake, [13] halt_bug, [21:14] mask_now, [29:22] flags_now,
    // [30] master_now, [31] zero
    output logic [31:0] m_tdata
);

    item_t      in_reg;
    logic       in_valid_reg;
    result_t    out_reg;
    logic       out_valid_reg;
    ctl_state_t state_reg;

    ctl_state_t state_next;
    result_t    res_next;
    logic       advance;
    logic       in_xfer;

    // Output register frees up when empty or when its transfer completes.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    cic_step u_step
    (
        .item (in_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Hold the event until the output register can take its result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_reg.mode            <= mode_t'(s_tuser);
            in_reg.instant         <= s_tdata[0];
            in_reg.source          <= s_tdata[3:1];
            in_reg.program_counter <= s_tdata[19:4];
            in_reg.write_value     <= s_tdata[27:20];
        end
    end

    // Commit controller state only when the event's result moves into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.master_enable   <= 1'b1;
            state_reg.enable_schedule <= SCHED_RESET;
            state_reg.enable_mask     <= MASK_RESET;
            state_reg.request_flags   <= FLAGS_RESET;
            state_reg.halt_latched    <= 1'b0;
            state_reg.halt_address    <= 16'h0000;
            out_valid_reg             <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.master_now, out_reg.flags_now, out_reg.mask_now,
                       out_reg.halt_bug, out_reg.joypad_wake, out_reg.chosen_source,
                       out_reg.vector, out_reg.serviced, out_reg.pending};

endmodule
